>>> design/wsl_pkg.sv
// shared types and constants for the station learning table
`timescale 1ns / 1ps
`default_nettype none

package wsl_pkg;

  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 12;
  localparam int TOTAL_W = 5;

  // header constants
  localparam logic [7:0]       BCAST_LEAD  = 8'hFF;
  localparam logic [LEN_W-1:0] MIN_HDR_LEN = 12'd24;
  localparam int               GROUP_BIT   = 40;

  typedef enum logic [1:0] {
    FT_MGMT = 2'd0,
    FT_CTRL = 2'd1,
    FT_DATA = 2'd2,
    FT_RSVD = 2'd3
  } frame_type_t;

  typedef enum logic [1:0] {
    DS_NONE = 2'd0,
    DS_TO   = 2'd1,
    DS_FROM = 2'd2,
    DS_BOTH = 2'd3
  } ds_t;

  typedef enum logic [2:0] {
    STAT_CLEARED   = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_KNOWN     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_IGNORED   = 3'd4,
    STAT_MULTICAST = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH,
    S_DONE
  } state_t;

  // outcome of header parsing
  typedef struct packed {
    logic              track;   // station must be looked up in the table
    logic [ADDR_W-1:0] sta;
    status_t           status;
  } ext_t;

endpackage

`default_nettype wire

>>> design/wsl_extract.sv
// bssid and station address extraction from one frame header
`timescale 1ns / 1ps
`default_nettype none

module wsl_extract (
  input  wire wsl_pkg::frame_type_t      frame_type,
  input  wire wsl_pkg::ds_t              ds,
  input  wire [wsl_pkg::LEN_W-1:0]       frame_length,
  input  wire [wsl_pkg::ADDR_W-1:0]      address_one,
  input  wire [wsl_pkg::ADDR_W-1:0]      address_two,
  input  wire [wsl_pkg::ADDR_W-1:0]      address_three,
  input  wire [wsl_pkg::ADDR_W-1:0]      target_bssid,
  output wsl_pkg::ext_t                  ext
);
  import wsl_pkg::*;

  logic              have_bssid;
  logic              have_sta;
  logic [ADDR_W-1:0] bssid;
  logic [ADDR_W-1:0] sta;
  logic              a1_bcast;

  assign a1_bcast = (address_one[ADDR_W-1 -: 8] == BCAST_LEAD);

  // pick bssid and station by frame type and ds bits
  always_comb begin
    have_bssid = 1'b0;
    have_sta   = 1'b0;
    bssid      = '0;
    sta        = '0;
    if (frame_length >= MIN_HDR_LEN) begin
      case (frame_type)
        FT_MGMT: begin
          bssid      = address_three;
          have_bssid = 1'b1;
          if (address_two != address_three) begin
            sta      = address_two;
            have_sta = 1'b1;
          end else if (address_one != address_three && !a1_bcast) begin
            sta      = address_one;
            have_sta = 1'b1;
          end
        end
        FT_DATA: begin
          case (ds)
            DS_NONE: begin
              bssid      = address_three;
              have_bssid = 1'b1;
              if (address_one != address_three && !a1_bcast) begin
                sta      = address_one;
                have_sta = 1'b1;
              end else if (address_two != address_three) begin
                sta      = address_two;
                have_sta = 1'b1;
              end
            end
            DS_TO: begin
              bssid      = address_two;
              have_bssid = 1'b1;
              if (address_one != address_two && !a1_bcast) begin
                sta      = address_one;
                have_sta = 1'b1;
              end
            end
            DS_FROM: begin
              bssid      = address_one;
              have_bssid = 1'b1;
              if (address_two != address_one) begin
                sta      = address_two;
                have_sta = 1'b1;
              end
            end
            default: begin
              // four-address frames are not tracked
              have_bssid = 1'b0;
            end
          endcase
        end
        default: begin
          have_bssid = 1'b0;
        end
      endcase
    end
  end

  // classify the station
  always_comb begin
    ext.track  = 1'b0;
    ext.sta    = have_sta ? sta : '0;
    ext.status = STAT_IGNORED;
    if (have_bssid && have_sta && bssid == target_bssid) begin
      if (sta[GROUP_BIT]) begin
        ext.status = STAT_MULTICAST;
      end else begin
        ext.track  = 1'b1;
        ext.status = STAT_ADDED;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/wsl_cell.sv
// one table cell: holds an entry, passes the search key and hit flag onward
`timescale 1ns / 1ps
`default_nettype none

module wsl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire                        clk,
  input  wire [wsl_pkg::ADDR_W-1:0]  key_in,
  input  wire                        hit_in,
  input  wire [wsl_pkg::ADDR_W-1:0]  entry_in,
  input  wire                        shift_en,
  input  wire [CW-1:0]               count,
  output logic [wsl_pkg::ADDR_W-1:0] key_out,
  output logic                       hit_out,
  output logic [wsl_pkg::ADDR_W-1:0] entry_out
);
  import wsl_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [ADDR_W-1:0] key;
  logic              hit;
  logic [ADDR_W-1:0] entry;
  logic              live;

  // entry counts only while it lies below the fill level
  assign live = (count > IDX_C);

  // key and hit advance one cell per cycle
  always_ff @(posedge clk) begin
    key <= key_in;
    hit <= hit_in | (live && entry == key_in);
  end

  // on insert the entries move one cell down the row
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
  end

  assign key_out   = key;
  assign hit_out   = hit;
  assign entry_out = entry;

endmodule

`default_nettype wire

>>> design/wlan_station_learning_table_unit.sv
// top level of the station learning table: control, cell row and output register
`timescale 1ns / 1ps
`default_nettype none

// Learns unicast stations of one configured BSSID from 802.11 header words.
// Each input word carries one header (or a clear request in tuser) and gives
// exactly one output word. A clear, or a frame that is ignored or multicast,
// goes from the evaluate state straight to the done state. A frame that needs
// a table lookup passes the search state: the key walks the row of cells one
// cell per cycle, and each cell compares it with the entry it holds. New
// stations enter at the head of the row and push older entries down. The
// output register holds a finished word until it is taken; the block works
// on the next word meanwhile and waits only if a second result is ready
// before the first has left. target_bssid must be written while idle.
module wlan_station_learning_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  // configuration
  input  wire         cfg_wr_en,
  input  wire [47:0]  cfg_wr_data,    // target_bssid
  // header words in
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [159:0] s_axis_tdata,   // frame_type_bits[1:0], ds_bits[3:2],
                                      // frame_length[15:4], address_one[63:16],
                                      // address_two[111:64], address_three[159:112]
  input  wire [0:0]   s_axis_tuser,   // action[0]
  // result words out
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,   // station_address[47:0], station_total[52:48],
                                      // zero[55:53]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import wsl_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] target_bssid;

  // latched header
  logic              action;
  frame_type_t       frame_type;
  ds_t               ds;
  logic [LEN_W-1:0]  frame_length;
  logic [ADDR_W-1:0] address_one;
  logic [ADDR_W-1:0] address_two;
  logic [ADDR_W-1:0] address_three;

  ext_t              ext;
  logic [ADDR_W-1:0] key;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt;
  status_t           res_status;
  logic [ADDR_W-1:0] res_sta;

  logic accept;
  logic eval;
  logic search_done;
  logic shift_en;
  logic out_load;
  logic hit;
  logic full;

  logic [ADDR_W-1:0] key_link   [TABLE_DEPTH];
  logic [ADDR_W-1:0] entry_link [TABLE_DEPTH];
  logic              hit_link   [TABLE_DEPTH+1];

  logic [CW+TOTAL_W-1:0] total_ext;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_bssid <= '0;
    end else if (cfg_wr_en) begin
      target_bssid <= cfg_wr_data;
    end
  end

  // header capture
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      action        <= s_axis_tuser[0];
      frame_type    <= frame_type_t'(s_axis_tdata[1:0]);
      ds            <= ds_t'(s_axis_tdata[3:2]);
      frame_length  <= s_axis_tdata[15:4];
      address_one   <= s_axis_tdata[63:16];
      address_two   <= s_axis_tdata[111:64];
      address_three <= s_axis_tdata[159:112];
    end
  end

  wsl_extract u_extract (
    .frame_type    (frame_type),
    .ds            (ds),
    .frame_length  (frame_length),
    .address_one   (address_one),
    .address_two   (address_two),
    .address_three (address_three),
    .target_bssid  (target_bssid),
    .ext           (ext)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!action && ext.track) state_next = S_SEARCH;
        else state_next = S_DONE;
      end
      S_SEARCH: begin
        if (cnt == DEPTH_C) state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs of the state machine
  always_comb begin
    s_axis_tready = 1'b0;
    eval          = 1'b0;
    search_done   = 1'b0;
    out_load      = 1'b0;
    case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_EVAL:   eval = 1'b1;
      S_SEARCH: search_done = (cnt == DEPTH_C);
      S_DONE:   out_load = !m_axis_tvalid || m_axis_tready;
      default:  s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // lookup outcome
  assign hit      = hit_link[TABLE_DEPTH];
  assign full     = (count == DEPTH_C);
  assign shift_en = search_done && !hit && !full;

  // search key, walk counter and pending result
  always_ff @(posedge clk) begin
    if (eval) begin
      key        <= ext.sta;
      cnt        <= '0;
      res_status <= action ? STAT_CLEARED : ext.status;
      res_sta    <= action ? '0 : ext.sta;
    end else if (state == S_SEARCH) begin
      cnt <= cnt + 1'b1;
      if (search_done) begin
        if (hit)       res_status <= STAT_KNOWN;
        else if (full) res_status <= STAT_FULL;
        else           res_status <= STAT_ADDED;
      end
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (eval && action) begin
      count <= '0;
    end else if (shift_en) begin
      count <= count + 1'b1;
    end
  end

  // row of cells
  assign key_link[0]   = key;
  assign entry_link[0] = key;
  assign hit_link[0]   = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i < TABLE_DEPTH - 1) begin : g_mid
      wsl_cell #(
        .IDX (i),
        .CW  (CW)
      ) u_cell (
        .clk       (clk),
        .key_in    (key_link[i]),
        .hit_in    (hit_link[i]),
        .entry_in  (entry_link[i]),
        .shift_en  (shift_en),
        .count     (count),
        .key_out   (key_link[i+1]),
        .hit_out   (hit_link[i+1]),
        .entry_out (entry_link[i+1])
      );
    end else begin : g_last
      wsl_cell #(
        .IDX (i),
        .CW  (CW)
      ) u_cell (
        .clk       (clk),
        .key_in    (key_link[i]),
        .hit_in    (hit_link[i]),
        .entry_in  (entry_link[i]),
        .shift_en  (shift_en),
        .count     (count),
        .key_out   (),
        .hit_out   (hit_link[i+1]),
        .entry_out ()
      );
    end
  end

  // output register
  assign total_ext = {{TOTAL_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, total_ext[TOTAL_W-1:0], res_sta};
      m_axis_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire
